### hw/rtl/cpu_operand_address_generator_core_defines.svh
// Assertion macros for the operand address generator.
// Included by RTL files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef CPU_OPERAND_ADDRESS_GENERATOR_CORE_DEFINES_SVH
`define CPU_OPERAND_ADDRESS_GENERATOR_CORE_DEFINES_SVH

// Check a property on every rising clock edge, masked while reset is asserted.
`define OPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition seen on an accepted item is followed by a result in the next cycle.
`define OPA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/opa_pkg.sv
// Shared types and constants for the 6502 operand address generator.
// No dependencies; used by the interfaces and imported by every RTL module.
package opa_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ModeW = 4;
  localparam int unsigned StepW = 2;

  localparam logic [ByteW-1:0] PageLastByte = 8'hFF;
  localparam logic [ByteW-1:0] ZeroByte     = 8'h00;

  typedef enum logic [ModeW-1:0] {
    MODE_ACC  = 4'd0,
    MODE_ABS  = 4'd1,
    MODE_ABSX = 4'd2,
    MODE_ABSY = 4'd3,
    MODE_IMM  = 4'd4,
    MODE_IMPL = 4'd5,
    MODE_IND  = 4'd6,
    MODE_XIND = 4'd7,
    MODE_INDY = 4'd8,
    MODE_REL  = 4'd9,
    MODE_ZPG  = 4'd10,
    MODE_ZPGX = 4'd11,
    MODE_ZPGY = 4'd12
  } mode_e;

  typedef enum logic {
    ITEM_START = 1'b0,
    ITEM_DATA  = 1'b1
  } item_kind_e;

  typedef enum logic [1:0] {
    RES_READ    = 2'd0,
    RES_DONE    = 2'd1,
    RES_IGNORED = 2'd2
  } res_kind_e;

  typedef enum logic [StepW-1:0] {
    STEP_0 = 2'd0,
    STEP_1 = 2'd1,
    STEP_2 = 2'd2,
    STEP_3 = 2'd3
  } step_e;

  typedef struct packed {
    logic             item_kind;
    logic [ModeW-1:0] mode;
    logic [AddrW-1:0] prog_counter;
    logic [ByteW-1:0] index_x;
    logic [ByteW-1:0] index_y;
    logic             is_rmw;
    logic [ByteW-1:0] read_data;
  } item_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [AddrW-1:0] read_address;
    logic [AddrW-1:0] effective_address;
    logic [AddrW-1:0] next_pc;
    logic             extra_cycle;
  } res_t;

endpackage

### hw/rtl/opa_item_if.sv
// Input channel of the operand address generator: valid/ready plus item fields.
// Depends on opa_pkg for field widths.
interface opa_item_if;
  logic                         valid;
  logic                         ready;
  logic                         item_kind;
  logic [opa_pkg::ModeW-1:0]    mode;
  logic [opa_pkg::AddrW-1:0]    prog_counter;
  logic [opa_pkg::ByteW-1:0]    index_x;
  logic [opa_pkg::ByteW-1:0]    index_y;
  logic                         is_rmw;
  logic [opa_pkg::ByteW-1:0]    read_data;

  modport source (
    output valid, item_kind, mode, prog_counter, index_x, index_y, is_rmw, read_data,
    input  ready
  );
  modport sink (
    input  valid, item_kind, mode, prog_counter, index_x, index_y, is_rmw, read_data,
    output ready
  );
endinterface

### hw/rtl/opa_result_if.sv
// Result channel of the operand address generator: valid/ready plus result fields.
// Depends on opa_pkg for field widths.
interface opa_result_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   result_kind;
  logic [opa_pkg::AddrW-1:0]    read_address;
  logic [opa_pkg::AddrW-1:0]    effective_address;
  logic [opa_pkg::AddrW-1:0]    next_pc;
  logic                         extra_cycle;

  modport source (
    output valid, result_kind, read_address, effective_address, next_pc, extra_cycle,
    input  ready
  );
  modport sink (
    input  valid, result_kind, read_address, effective_address, next_pc, extra_cycle,
    output ready
  );
endinterface

### hw/rtl/opa_in_reg.sv
// Input register stage: captures one item from the input channel.
// Depends on opa_pkg and opa_item_if.
module opa_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  opa_item_if.sink         item_i,
  input  logic             take_i,
  output logic             valid_o,
  output opa_pkg::item_t   item_o
);
  import opa_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  // Free when empty or when the held item moves on this cycle.
  assign item_i.ready = !valid_q || take_i;
  assign accept       = item_i.valid && item_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.item_kind    <= item_i.item_kind;
      item_q.mode         <= item_i.mode;
      item_q.prog_counter <= item_i.prog_counter;
      item_q.index_x      <= item_i.index_x;
      item_q.index_y      <= item_i.index_y;
      item_q.is_rmw       <= item_i.is_rmw;
      item_q.read_data    <= item_i.read_data;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hw/rtl/opa_step.sv
// Addressing-mode sequencer: holds the per-instruction context and turns each item into
// one read request, done or ignored result. Depends on opa_pkg and the defines header.
`include "cpu_operand_address_generator_core_defines.svh"

module opa_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  opa_pkg::item_t   item_i,
  output opa_pkg::res_t    res_o
);
  import opa_pkg::*;

  logic             busy_q, busy_d;
  mode_e            held_mode_q, held_mode_d;
  logic [AddrW-1:0] work_pc_q, work_pc_d;
  logic [ByteW-1:0] held_x_q, held_x_d;
  logic [ByteW-1:0] held_y_q, held_y_d;
  logic             held_rmw_q, held_rmw_d;
  step_e            step_q, step_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [ByteW-1:0] low_q, low_d;

  logic [ByteW-1:0] rd;
  logic [AddrW-1:0] word_rd;
  logic [ByteW-1:0] abs_idx;
  logic [ByteW:0]   low_sum;
  logic [ByteW:0]   low_sum_y;
  logic [ByteW-1:0] zp_ptr;
  logic [ByteW-1:0] zp_ptr_next;
  logic [AddrW-1:0] ind_hi_addr;
  res_t             res;

  assign rd      = item_i.read_data;
  assign word_rd = {rd, low_q};
  assign abs_idx = (held_mode_q == MODE_ABSX) ? held_x_q :
                   (held_mode_q == MODE_ABSY) ? held_y_q : ZeroByte;
  assign low_sum     = {1'b0, low_q} + {1'b0, abs_idx};
  assign low_sum_y   = {1'b0, low_q} + {1'b0, held_y_q};
  assign zp_ptr      = (held_mode_q == MODE_XIND) ? rd + held_x_q : rd;
  assign zp_ptr_next = ptr_q[ByteW-1:0] + 8'd1;
  // Indirect jump quirk: a pointer at the end of a page wraps to its start.
  assign ind_hi_addr = (ptr_q[ByteW-1:0] == PageLastByte) ? {ptr_q[AddrW-1:ByteW], ZeroByte}
                                                          : ptr_q + 16'd1;

  always_comb begin
    busy_d      = busy_q;
    held_mode_d = held_mode_q;
    work_pc_d   = work_pc_q;
    held_x_d    = held_x_q;
    held_y_d    = held_y_q;
    held_rmw_d  = held_rmw_q;
    step_d      = step_q;
    ptr_d       = ptr_q;
    low_d       = low_q;
    res         = '0;

    if (item_i.item_kind == ITEM_START) begin
      held_mode_d = mode_e'(item_i.mode);
      held_x_d    = item_i.index_x;
      held_y_d    = item_i.index_y;
      held_rmw_d  = item_i.is_rmw;
      step_d      = STEP_0;
      busy_d      = 1'b0;
      work_pc_d   = item_i.prog_counter;
      if (item_i.mode == MODE_IMM) begin
        work_pc_d             = item_i.prog_counter + 16'd1;
        res.result_kind       = RES_DONE;
        res.effective_address = item_i.prog_counter;
        res.next_pc           = item_i.prog_counter + 16'd1;
      end else if (item_i.mode == MODE_ACC || item_i.mode == MODE_IMPL ||
                   item_i.mode > MODE_ZPGY) begin
        res.result_kind = RES_DONE;
        res.next_pc     = item_i.prog_counter;
      end else begin
        busy_d           = 1'b1;
        work_pc_d        = item_i.prog_counter + 16'd1;
        res.result_kind  = RES_READ;
        res.read_address = item_i.prog_counter;
      end
    end else if (!busy_q) begin
      res.result_kind = RES_IGNORED;
    end else begin
      // Default to a done result; request arms below override it.
      res.result_kind = RES_DONE;
      res.next_pc     = work_pc_q;
      busy_d          = 1'b0;
      step_d          = STEP_0;
      case (held_mode_q)
        MODE_ABS, MODE_ABSX, MODE_ABSY: begin
          if (step_q == STEP_0) begin
            low_d            = rd;
            step_d           = STEP_1;
            busy_d           = 1'b1;
            work_pc_d        = work_pc_q + 16'd1;
            res              = '0;
            res.result_kind  = RES_READ;
            res.read_address = work_pc_q;
          end else begin
            res.effective_address = word_rd + {ZeroByte, abs_idx};
            res.extra_cycle       = (held_mode_q != MODE_ABS) && !held_rmw_q && low_sum[ByteW];
          end
        end
        MODE_IND: begin
          if (step_q != STEP_3) begin
            busy_d          = 1'b1;
            res             = '0;
            res.result_kind = RES_READ;
          end
          case (step_q)
            STEP_0: begin
              low_d            = rd;
              step_d           = STEP_1;
              work_pc_d        = work_pc_q + 16'd1;
              res.read_address = work_pc_q;
            end
            STEP_1: begin
              ptr_d            = word_rd;
              step_d           = STEP_2;
              res.read_address = word_rd;
            end
            STEP_2: begin
              low_d            = rd;
              step_d           = STEP_3;
              res.read_address = ind_hi_addr;
            end
            default: begin
              res.effective_address = word_rd;
            end
          endcase
        end
        MODE_XIND, MODE_INDY: begin
          if (step_q == STEP_0) begin
            ptr_d            = {ZeroByte, zp_ptr};
            step_d           = STEP_1;
            busy_d           = 1'b1;
            res              = '0;
            res.result_kind  = RES_READ;
            res.read_address = {ZeroByte, zp_ptr};
          end else if (step_q == STEP_1) begin
            low_d            = rd;
            step_d           = STEP_2;
            busy_d           = 1'b1;
            res              = '0;
            res.result_kind  = RES_READ;
            res.read_address = {ZeroByte, zp_ptr_next};
          end else if (held_mode_q == MODE_XIND) begin
            res.effective_address = word_rd;
          end else begin
            res.effective_address = word_rd + {ZeroByte, held_y_q};
            res.extra_cycle       = low_sum_y[ByteW];
          end
        end
        MODE_REL:  res.effective_address = {{ByteW{rd[ByteW-1]}}, rd};
        MODE_ZPG:  res.effective_address = {ZeroByte, rd};
        MODE_ZPGX: res.effective_address = {ZeroByte, rd + held_x_q};
        MODE_ZPGY: res.effective_address = {ZeroByte, rd + held_y_q};
        default:   res.effective_address = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= STEP_0;
      held_mode_q <= MODE_ACC;
      work_pc_q   <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      held_rmw_q  <= 1'b0;
      ptr_q       <= '0;
      low_q       <= '0;
    end else if (fire_i) begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      held_mode_q <= held_mode_d;
      work_pc_q   <= work_pc_d;
      held_x_q    <= held_x_d;
      held_y_q    <= held_y_d;
      held_rmw_q  <= held_rmw_d;
      ptr_q       <= ptr_d;
      low_q       <= low_d;
    end
  end

  assign res_o = res;

  `OPA_ASSERT(a_idle_step_zero, !busy_q |-> step_q == STEP_0,
              "step counter nonzero while idle")
  `OPA_ASSERT(a_step3_only_ind, step_q == STEP_3 |-> held_mode_q == MODE_IND,
              "fourth step reached outside indirect mode")
  `OPA_ASSERT_NEXT(a_done_clears_busy, fire_i && res.result_kind == RES_DONE,
                   !busy_q && step_q == STEP_0, "done result left the sequencer busy")
  `OPA_ASSERT_NEXT(a_read_keeps_busy, fire_i && res.result_kind == RES_READ, busy_q,
                   "read request issued without a pending computation")

endmodule

### hw/rtl/opa_out_reg.sv
// Result register: holds one result until the output channel takes it.
// Depends on opa_pkg and opa_result_if.
module opa_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  opa_pkg::res_t    res_i,
  output logic             take_o,
  opa_result_if.source     result_o
);
  import opa_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Load a new result when empty or when the held one leaves this cycle.
  assign take_o = valid_i && (!valid_q || result_o.ready);

  always_comb begin
    valid_d = valid_q;
    if (take_o) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid             = valid_q;
  assign result_o.result_kind       = res_q.result_kind;
  assign result_o.read_address      = res_q.read_address;
  assign result_o.effective_address = res_q.effective_address;
  assign result_o.next_pc           = res_q.next_pc;
  assign result_o.extra_cycle       = res_q.extra_cycle;

endmodule

### hw/rtl/cpu_operand_address_generator_core.sv
// 6502 operand address generator. A start item (mode, PC, X, Y, read-modify-write flag)
// and each returned bus byte produce exactly one result: a bus read request, a done
// result with effective address, next PC and page-cross flag, or an ignored result for
// a byte seen while idle. One item is accepted per cycle while the result channel does
// not stall; each item is held in the input register, passes once through the mode
// sequencer and is registered in the result register before it appears on the output.
module cpu_operand_address_generator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  opa_item_if.sink     item_i,
  opa_result_if.source result_o
);
  import opa_pkg::*;

  logic  in_valid;
  logic  take;
  item_t item;
  res_t  res;

  opa_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .take_i  (take),
    .valid_o (in_valid),
    .item_o  (item)
  );

  opa_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (take),
    .item_i (item),
    .res_o  (res)
  );

  opa_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid),
    .res_i    (res),
    .take_o   (take),
    .result_o (result_o)
  );

endmodule

### tb/cpu_operand_address_generator_core_tb.sv
`timescale 1ns / 100ps
// Testbench for cpu_operand_address_generator_core: directed table, then random start/data items.
// Results are predicted in-bench and checked field by field; uses opa_pkg and the two channel
// interfaces from the RTL.
module cpu_operand_address_generator_core_tb;
  import opa_pkg::*;

  localparam logic [ModeW-1:0] MODE_UNUSED_MAX = 4'd15;
  localparam int RandItems  = 925;
  localparam int HoldCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #10 clk_i = ~clk_i;

  opa_item_if   item_bus ();
  opa_result_if res_bus ();

  cpu_operand_address_generator_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (res_bus)
  );

  // Shadow copy of the address sequencer state
  logic             op_busy;
  logic [ModeW-1:0] op_mode;
  logic [AddrW-1:0] op_pc;
  logic [ByteW-1:0] op_x;
  logic [ByteW-1:0] op_y;
  logic             op_rmw;
  step_e            op_step;
  logic [AddrW-1:0] op_ptr;
  logic [ByteW-1:0] op_low;

  res_t pending_results [$];
  int   items_accepted;
  int   results_seen;
  int   n_errors;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  bit   hold_now;
  int   hold_left;
  bit   offer_fixed;
  res_t offer_fixed_res;

  typedef struct packed {
    item_t stim;
    bit    has_fixed;
    res_t  fixed;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic res_t make_res(res_kind_e k, logic [AddrW-1:0] ra, logic [AddrW-1:0] ea,
                                    logic [AddrW-1:0] npc, logic ex);
    res_t r;
    r.result_kind       = k;
    r.read_address      = ra;
    r.effective_address = ea;
    r.next_pc           = npc;
    r.extra_cycle       = ex;
    return r;
  endfunction

  function automatic res_t finish_op(logic [AddrW-1:0] ea, logic ex);
    op_busy = 1'b0;
    op_step = STEP_0;
    return make_res(RES_DONE, '0, ea, op_pc, ex);
  endfunction

  // Request the next operand byte and advance the PC
  function automatic res_t fetch_next();
    res_t r;
    r     = make_res(RES_READ, op_pc, '0, '0, 1'b0);
    op_pc = op_pc + 16'd1;
    return r;
  endfunction

  function automatic res_t step_operand_addr(item_t it);
    logic [ByteW-1:0] d;
    logic [ByteW-1:0] idx;
    logic [ByteW-1:0] zp;
    logic [ByteW:0]   low_sum;
    d = it.read_data;
    if (it.item_kind == ITEM_START) begin
      op_mode = it.mode;
      op_pc   = it.prog_counter;
      op_x    = it.index_x;
      op_y    = it.index_y;
      op_rmw  = it.is_rmw;
      op_step = STEP_0;
      op_busy = 1'b0;
      if (op_mode == MODE_IMM) begin
        op_pc = op_pc + 16'd1;
        return make_res(RES_DONE, '0, it.prog_counter, op_pc, 1'b0);
      end
      if (op_mode == MODE_ACC || op_mode == MODE_IMPL || op_mode > MODE_ZPGY)
        return finish_op('0, 1'b0);
      op_busy = 1'b1;
      return fetch_next();
    end
    if (!op_busy) return make_res(RES_IGNORED, '0, '0, '0, 1'b0);
    case (op_mode)
      MODE_ABS, MODE_ABSX, MODE_ABSY: begin
        if (op_step == STEP_0) begin
          op_low  = d;
          op_step = STEP_1;
          return fetch_next();
        end
        idx     = (op_mode == MODE_ABSX) ? op_x : (op_mode == MODE_ABSY) ? op_y : 8'h00;
        low_sum = op_low + idx;
        return finish_op({d, op_low} + idx, op_mode != MODE_ABS && !op_rmw && low_sum[ByteW]);
      end
      MODE_IND: begin
        case (op_step)
          STEP_0: begin
            op_low  = d;
            op_step = STEP_1;
            return fetch_next();
          end
          STEP_1: begin
            op_ptr  = {d, op_low};
            op_step = STEP_2;
            return make_res(RES_READ, op_ptr, '0, '0, 1'b0);
          end
          STEP_2: begin
            op_low  = d;
            op_step = STEP_3;
            // high byte never carries into the next page
            return make_res(RES_READ, {op_ptr[15:8], op_ptr[7:0] + 8'd1}, '0, '0, 1'b0);
          end
          default: return finish_op({d, op_low}, 1'b0);
        endcase
      end
      MODE_XIND, MODE_INDY: begin
        case (op_step)
          STEP_0: begin
            zp      = (op_mode == MODE_XIND) ? d + op_x : d;
            op_ptr  = {8'h00, zp};
            op_step = STEP_1;
            return make_res(RES_READ, op_ptr, '0, '0, 1'b0);
          end
          STEP_1: begin
            op_low  = d;
            op_step = STEP_2;
            zp      = op_ptr[7:0] + 8'd1;
            return make_res(RES_READ, {8'h00, zp}, '0, '0, 1'b0);
          end
          default: begin
            if (op_mode == MODE_XIND) return finish_op({d, op_low}, 1'b0);
            low_sum = op_low + op_y;
            return finish_op({d, op_low} + op_y, low_sum[ByteW]);
          end
        endcase
      end
      MODE_REL:  return finish_op({{8{d[7]}}, d}, 1'b0);
      MODE_ZPG:  return finish_op({8'h00, d}, 1'b0);
      MODE_ZPGX: begin
        zp = d + op_x;
        return finish_op({8'h00, zp}, 1'b0);
      end
      MODE_ZPGY: begin
        zp = d + op_y;
        return finish_op({8'h00, zp}, 1'b0);
      end
      default:   return finish_op('0, 1'b0);
    endcase
  endfunction

  function automatic int reads_needed(logic [ModeW-1:0] m);
    case (m)
      MODE_ABS, MODE_ABSX, MODE_ABSY:      return 2;
      MODE_IND:                            return 4;
      MODE_XIND, MODE_INDY:                return 3;
      MODE_REL, MODE_ZPG, MODE_ZPGX, MODE_ZPGY: return 1;
      default:                             return 0;
    endcase
  endfunction

  function automatic item_t start_item(logic [ModeW-1:0] m, logic [AddrW-1:0] pc,
                                       logic [ByteW-1:0] x, logic [ByteW-1:0] y, logic rmw);
    item_t it;
    it              = '0;
    it.item_kind    = ITEM_START;
    it.mode         = m;
    it.prog_counter = pc;
    it.index_x      = x;
    it.index_y      = y;
    it.is_rmw       = rmw;
    return it;
  endfunction

  function automatic item_t data_item(logic [ByteW-1:0] d);
    item_t it;
    it           = '0;
    it.item_kind = ITEM_DATA;
    it.read_data = d;
    return it;
  endfunction

  // Favor page-edge and sign-bit bytes
  function automatic logic [ByteW-1:0] pick_byte();
    logic [ByteW-1:0] b;
    case ($urandom_range(0, 5))
      0:       b = 8'hFF;
      1:       b = 8'h00;
      2:       b = 8'h80;
      default: b = ByteW'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Fill every field at random; the kind decides which ones matter
  function automatic item_t rand_item(item_kind_e k);
    item_t it;
    it.item_kind    = k;
    it.mode         = ModeW'($urandom_range(0, 15));
    it.prog_counter = AddrW'($urandom_range(0, 65535));
    it.index_x      = pick_byte();
    it.index_y      = pick_byte();
    it.is_rmw       = 1'($urandom_range(0, 1));
    it.read_data    = pick_byte();
    if (k == ITEM_START) begin
      if ($urandom_range(0, 19) == 0) begin
        it.mode = ModeW'($urandom_range(MODE_ZPGY + 1, MODE_UNUSED_MAX));
      end else begin
        it.mode = ModeW'($urandom_range(MODE_ACC, MODE_ZPGY));
      end
      if ($urandom_range(0, 3) == 0) it.prog_counter[7:0] = pick_byte();
    end
    return it;
  endfunction

  task automatic send_item(item_t it, bit fx, res_t fx_res);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_bus.valid        <= 1'b1;
    item_bus.item_kind    <= it.item_kind;
    item_bus.mode         <= it.mode;
    item_bus.prog_counter <= it.prog_counter;
    item_bus.index_x      <= it.index_x;
    item_bus.index_y      <= it.index_y;
    item_bus.is_rmw       <= it.is_rmw;
    item_bus.read_data    <= it.read_data;
    offer_fixed           <= fx;
    offer_fixed_res       <= fx_res;
    do @(posedge clk_i); while (!item_bus.ready);
    items_accepted++;
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    wait (results_seen >= items_accepted);
    @(posedge clk_i);
  endtask

  task automatic check_field(string fname, logic [AddrW-1:0] want, logic [AddrW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
      n_errors++;
    end
  endtask

  // Predict on input acceptance, compare on result acceptance
  always @(posedge clk_i) begin
    item_t got_item;
    res_t  got_res;
    res_t  want;
    if (rst_ni) begin
      if (item_bus.valid && item_bus.ready) begin
        got_item = {item_bus.item_kind, item_bus.mode, item_bus.prog_counter, item_bus.index_x,
                    item_bus.index_y, item_bus.is_rmw, item_bus.read_data};
        want = step_operand_addr(got_item);
        if (offer_fixed) want = offer_fixed_res;
        pending_results.push_back(want);
      end
      if (res_bus.valid && res_bus.ready) begin
        got_res = {res_bus.result_kind, res_bus.read_address, res_bus.effective_address,
                   res_bus.next_pc, res_bus.extra_cycle};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, got_res);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", 16'(want.result_kind), 16'(got_res.result_kind));
          check_field("read_address", want.read_address, got_res.read_address);
          check_field("effective_address", want.effective_address, got_res.effective_address);
          check_field("next_pc", want.next_pc, got_res.next_pc);
          check_field("extra_cycle", 16'(want.extra_cycle), 16'(got_res.extra_cycle));
        end
        results_seen++;
      end
    end
  end

  // Result side: random stalls plus one long hold-off on request
  initial begin
    res_bus.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_now) begin
        hold_now  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    item_t seq_start;
    int    n_reads;
    int    pick;
    int    n_items;
    op_busy = 1'b0; op_mode = '0; op_pc = '0; op_x = '0; op_y = '0;
    op_rmw = 1'b0; op_step = STEP_0; op_ptr = '0; op_low = '0;
    items_accepted = 0;
    results_seen   = 0;
    n_errors       = 0;
    n_items        = 0;
    hold_now       = 1'b0;
    snd_idle_pct   = 38;
    rcv_idle_pct   = 87;
    rst_ni                <= 1'b0;
    item_bus.valid        <= 1'b0;
    item_bus.item_kind    <= ITEM_START;
    item_bus.mode         <= '0;
    item_bus.prog_counter <= '0;
    item_bus.index_x      <= '0;
    item_bus.index_y      <= '0;
    item_bus.is_rmw       <= 1'b0;
    item_bus.read_data    <= '0;
    offer_fixed           <= 1'b0;
    offer_fixed_res       <= '0;

    // data while idle, the no-read modes, page and sign edges, abandoned sequences
    dir_rows.push_back('{data_item(8'hFF), 1'b1, make_res(RES_IGNORED, '0, '0, '0, 1'b0)});
    dir_rows.push_back('{start_item(MODE_IMM, 16'hFFFF, 8'h00, 8'h00, 1'b0), 1'b1,
                         make_res(RES_DONE, '0, 16'hFFFF, 16'h0000, 1'b0)});
    dir_rows.push_back('{start_item(MODE_UNUSED_MAX, 16'h1234, 8'hFF, 8'hFF, 1'b1), 1'b1,
                         make_res(RES_DONE, '0, 16'h0000, 16'h1234, 1'b0)});
    dir_rows.push_back('{start_item(MODE_ABSX, 16'hFFFF, 8'hFF, 8'h00, 1'b0), 1'b1,
                         make_res(RES_READ, 16'hFFFF, '0, '0, 1'b0)});
    dir_rows.push_back('{data_item(8'hFF), 1'b1, make_res(RES_READ, 16'h0000, '0, '0, 1'b0)});
    dir_rows.push_back('{data_item(8'hFF), 1'b1,
                         make_res(RES_DONE, '0, 16'h00FE, 16'h0001, 1'b1)});
    dir_rows.push_back('{start_item(MODE_IND, 16'h2000, 8'h00, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{data_item(8'hFF), 1'b0, '0});
    dir_rows.push_back('{data_item(8'h30), 1'b0, '0});
    dir_rows.push_back('{data_item(8'h34), 1'b0, '0});
    dir_rows.push_back('{data_item(8'h12), 1'b0, '0});
    dir_rows.push_back('{start_item(MODE_INDY, 16'h0000, 8'h00, 8'hFF, 1'b1), 1'b0, '0});
    dir_rows.push_back('{data_item(8'hFF), 1'b0, '0});
    dir_rows.push_back('{data_item(8'h80), 1'b0, '0});
    dir_rows.push_back('{data_item(8'hFF), 1'b0, '0});
    dir_rows.push_back('{start_item(MODE_REL, 16'h8000, 8'h00, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{data_item(8'h80), 1'b1,
                         make_res(RES_DONE, '0, 16'hFF80, 16'h8001, 1'b0)});
    dir_rows.push_back('{start_item(MODE_XIND, 16'h6000, 8'hFF, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back('{data_item(8'h01), 1'b0, '0});
    dir_rows.push_back('{start_item(MODE_ZPGY, 16'h5000, 8'h00, 8'hFF, 1'b0), 1'b0, '0});
    dir_rows.push_back('{data_item(8'h02), 1'b0, '0});
    dir_rows.push_back('{start_item(MODE_ACC, 16'hFFFF, 8'hFF, 8'hFF, 1'b1), 1'b1,
                         make_res(RES_DONE, '0, 16'h0000, 16'hFFFF, 1'b0)});
    dir_rows.push_back('{start_item(MODE_ABSY, 16'h7FFF, 8'h00, 8'h80, 1'b1), 1'b0, '0});
    dir_rows.push_back('{data_item(8'h90), 1'b0, '0});
    dir_rows.push_back('{data_item(8'h00), 1'b0, '0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].has_fixed, dir_rows[i].fixed);
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 38; rcv_idle_pct = 87; end
        1: begin snd_idle_pct = 87; rcv_idle_pct = 38; end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
          hold_now     = 1'b1;
        end
      endcase
      while (n_items < (ph + 1) * RandItems / 3) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // stray data, mostly ignored
          send_item(rand_item(ITEM_DATA), 1'b0, '0);
          n_items++;
        end else begin
          seq_start = rand_item(ITEM_START);
          n_reads   = reads_needed(seq_start.mode);
          // cut the sequence short so the next start abandons it
          if (pick < 18 && n_reads > 0) n_reads = int'($urandom_range(0, n_reads - 1));
          send_item(seq_start, 1'b0, '0);
          n_items++;
          repeat (n_reads) begin
            send_item(rand_item(ITEM_DATA), 1'b0, '0);
            n_items++;
          end
        end
      end
      drain_results();
    end

    repeat (6) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
